### hdl/b64e_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// b64e_pkg
// Shared types, constants and the sextet-to-character mapping for the
// Base64 stream encoder.
// ----------------------------------------------------------------------------
package b64e_pkg;

    localparam int unsigned CHAR_W = 7;

    localparam logic [CHAR_W-1:0] C_PAD   = 7'h3D;  // '='
    localparam logic [CHAR_W-1:0] C_PLUS  = 7'h2B;  // '+'
    localparam logic [CHAR_W-1:0] C_SLASH = 7'h2F;  // '/'
    localparam logic [CHAR_W-1:0] C_UPPER = 7'h41;  // 'A'
    localparam logic [CHAR_W-1:0] C_LOWER = 7'h61;  // 'a'
    localparam logic [CHAR_W-1:0] C_DIGIT = 7'h30;  // '0'

    // One closed group of up to three bytes, as handed to the back end.
    typedef struct packed {
        logic [23:0] bits;    // first byte in bits 23..16, missing bytes zero
        logic [1:0]  nbytes;  // 1..3 bytes given
        logic        last;    // group closed by the final byte of the message
    } t_group;

    function automatic logic [CHAR_W-1:0] sextet_char(input logic [5:0] idx);
        logic [CHAR_W-1:0] code;
        if (idx < 6'd26) begin
            code = C_UPPER + CHAR_W'(idx);
        end else if (idx < 6'd52) begin
            code = C_LOWER + CHAR_W'(idx - 6'd26);
        end else if (idx < 6'd62) begin
            code = C_DIGIT + CHAR_W'(idx - 6'd52);
        end else if (idx == 6'd62) begin
            code = C_PLUS;
        end else begin
            code = C_SLASH;
        end
        return code;
    endfunction

endpackage
`default_nettype wire

### hdl/b64e_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// b64e_front
// Accepts message bytes, holds up to two pending bytes and closes a group
// on every third byte or on the final byte of the message.
// ----------------------------------------------------------------------------
module b64e_front (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_accept,
    input  wire logic [7:0]       i_data_byte,
    input  wire logic             i_message_last,
    output b64e_pkg::t_group      o_group,
    output logic                  o_group_push
);

    logic [15:0] r_pend;
    logic [15:0] n_pend;
    logic [1:0]  r_cnt;
    logic [1:0]  n_cnt;
    logic        close;

    // A group closes on the third byte or on the final byte of a message.
    assign close        = (r_cnt == 2'd2) || i_message_last;
    assign o_group_push = i_accept && close;

    always_comb begin
        unique case (r_cnt)
            2'd0:    o_group.bits = {i_data_byte, 16'h0000};
            2'd1:    o_group.bits = {r_pend[15:8], i_data_byte, 8'h00};
            default: o_group.bits = {r_pend, i_data_byte};
        endcase
        o_group.nbytes = (r_cnt == 2'd3) ? 2'd3 : r_cnt + 2'd1;
        o_group.last   = i_message_last;
    end

    always_comb begin
        n_pend = r_pend;
        n_cnt  = r_cnt;
        if (i_accept) begin
            if (close) begin
                n_pend = 16'h0000;
                n_cnt  = 2'd0;
            end else if (r_cnt == 2'd0) begin
                n_pend = {i_data_byte, 8'h00};
                n_cnt  = 2'd1;
            end else begin
                n_pend = {r_pend[15:8], i_data_byte};
                n_cnt  = 2'd2;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= 16'h0000;
            r_cnt  <= 2'd0;
        end else begin
            r_pend <= n_pend;
            r_cnt  <= n_cnt;
        end
    end

endmodule
`default_nettype wire

### hdl/b64e_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// b64e_queue
// Short register queue of closed groups between the front and back ends.
// ----------------------------------------------------------------------------
module b64e_queue #(
    parameter int unsigned DEPTH = 2
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire b64e_pkg::t_group i_data,
    output logic                  o_full,
    input  wire logic             i_pop,
    output b64e_pkg::t_group      o_data,
    output logic                  o_empty
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

    b64e_pkg::t_group r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == LAST_PTR) ? '0 : r_wr + PTR_W'(1);
            end
            if (do_pop) begin
                r_rd <= (r_rd == LAST_PTR) ? '0 : r_rd + PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

endmodule
`default_nettype wire

### hdl/b64e_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// b64e_back
// Takes closed groups from the queue and sends out four characters each,
// one per cycle while the output register is drained, through that register.
// ----------------------------------------------------------------------------
module b64e_back (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_q_empty,
    input  wire b64e_pkg::t_group                  i_q_data,
    output logic                                   o_q_pop,
    output logic                                   o_empty,
    input  wire logic                              i_pop,
    output logic [b64e_pkg::CHAR_W-1:0]            o_char_code,
    output logic                                   o_run_end,
    output logic                                   o_message_end
);

    b64e_pkg::t_group              r_group;
    logic                          r_busy;
    logic [1:0]                    r_idx;
    logic                          r_ov;
    logic [b64e_pkg::CHAR_W-1:0]   r_char;
    logic                          r_run_end;
    logic                          r_msg_end;
    logic                          out_adv;
    logic                          emit;
    logic                          pad;
    logic [5:0]                    sextet;
    logic [b64e_pkg::CHAR_W-1:0]   char_code;

    assign out_adv = !r_ov || i_pop;
    assign emit    = r_busy && out_adv;
    // The next group is loaded while the fourth character of this one leaves.
    assign o_q_pop = !i_q_empty && (!r_busy || (emit && r_idx == 2'd3));

    always_comb begin
        unique case (r_idx)
            2'd0:    sextet = r_group.bits[23:18];
            2'd1:    sextet = r_group.bits[17:12];
            2'd2:    sextet = r_group.bits[11:6];
            default: sextet = r_group.bits[5:0];
        endcase
        pad = ((r_idx == 2'd3) && (r_group.nbytes != 2'd3))
           || ((r_idx == 2'd2) && (r_group.nbytes == 2'd1));
        char_code = pad ? b64e_pkg::C_PAD : b64e_pkg::sextet_char(sextet);
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_group <= i_q_data;
        end
        if (emit) begin
            r_char    <= char_code;
            r_run_end <= (r_idx == 2'd3);
            r_msg_end <= (r_idx == 2'd3) && r_group.last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= 2'd0;
            r_ov   <= 1'b0;
        end else begin
            if (o_q_pop) begin
                r_busy <= 1'b1;
                r_idx  <= 2'd0;
            end else if (emit) begin
                r_idx <= r_idx + 2'd1;
                if (r_idx == 2'd3) begin
                    r_busy <= 1'b0;
                end
            end
            if (emit) begin
                r_ov <= 1'b1;
            end else if (i_pop) begin
                r_ov <= 1'b0;
            end
        end
    end

    assign o_empty       = !r_ov;
    assign o_char_code   = r_char;
    assign o_run_end     = r_run_end;
    assign o_message_end = r_msg_end;

endmodule
`default_nettype wire

### hdl/base64_stream_encoder.sv
`default_nettype none
// ----------------------------------------------------------------------------
// base64_stream_encoder
// Streaming Base64 encoder: one byte in per item, one character out per item.
// ----------------------------------------------------------------------------
// The group that a byte closes enters the queue when that byte is accepted,
// then passes to the back end's group register, and its first character
// then passes to the output register.
// Throughput: one character per cycle while pop drains the output, set by
// the back end's single output register; a byte is taken every cycle while
// the group queue has room. Reset: synchronous active-low reset empties the
// queue and output and drops any pending bytes.
// ----------------------------------------------------------------------------
module base64_stream_encoder #(
    parameter int unsigned QUEUE_DEPTH = 2
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         push,
    output logic                              full,
    input  wire logic [7:0]                   i_data_byte,
    input  wire logic                         i_message_last,
    output logic                              empty,
    input  wire logic                         pop,
    output logic [b64e_pkg::CHAR_W-1:0]       o_char_code,
    output logic                              o_run_end,
    output logic                              o_message_end
);

    b64e_pkg::t_group q_wr_data;
    b64e_pkg::t_group q_rd_data;
    logic             q_push;
    logic             q_full;
    logic             q_empty;
    logic             q_pop;
    logic             accept;

    // Conservative: bytes are held off whenever the queue is full.
    assign full   = q_full;
    assign accept = push && !q_full;

    b64e_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (accept),
        .i_data_byte    (i_data_byte),
        .i_message_last (i_message_last),
        .o_group        (q_wr_data),
        .o_group_push   (q_push)
    );

    b64e_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_wr_data),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_data  (q_rd_data),
        .o_empty (q_empty)
    );

    b64e_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_empty     (q_empty),
        .i_q_data      (q_rd_data),
        .o_q_pop       (q_pop),
        .o_empty       (empty),
        .i_pop         (pop),
        .o_char_code   (o_char_code),
        .o_run_end     (o_run_end),
        .o_message_end (o_message_end)
    );

    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> !q_full)
        else $error("group pushed into a full queue");

    a_pop_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> !q_empty)
        else $error("group popped from an empty queue");

    a_end_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_message_end) |-> o_run_end)
        else $error("message end flagged away from a group boundary");

endmodule
`default_nettype wire
